### rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   // Default list depth and the element word width.
   localparam int PLE_DEPTH = 32;
   localparam int WORD_W    = 32;
   localparam int POS_W     = 8;
   localparam int LEVEL_W   = 6;

   // Request opcodes; the unused code falls to the default arm wherever decoded.
   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } ple_op_type;

   // What every cell does at a clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } ple_cmd_type;

   // Control word broadcast to the whole row of cells.
   typedef struct packed {
      ple_cmd_type              cmd;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] write_value;
   } ple_ctrl_type;

endpackage

`default_nettype wire

### rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: request decode, fill count and response register.
// Depends on ple_pkg and ple_cell.
`timescale 1ns / 1ps
`default_nettype none

// The list lives in a row of DEPTH cells, one word each. An insert or delete
// moves every affected cell to its neighbor's word at the same clock edge, and
// a read or delete picks the addressed cell off a merged select bus. The
// response word is registered and appears the cycle after acceptance; a new
// request is taken in the same cycle that the previous response is taken, so
// the block sustains one request per cycle while rsp_ready is high. The fill
// count resets to zero; the cell words are not cleared and need no clearing
// pass, since only positions 1 up to the count are ever read. fill_level shows the count modulo 64.
module positional_list_engine_unit
   import ple_pkg::*;
#(
   parameter int DEPTH = PLE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [WORD_W-1:0] req_write_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_status,
   output logic signed [WORD_W-1:0]      rsp_read_value,
   output logic [LEVEL_W-1:0]            rsp_fill_level
);

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [CW-1:0]            fill_ff;
   logic [CW-1:0]            fill_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_status_ff;
   logic signed [WORD_W-1:0] rsp_read_value_ff;
   logic [LEVEL_W-1:0]       rsp_fill_level_ff;

   logic                     accept;
   logic                     ok;
   logic                     ins_ok;
   logic                     del_ok;
   logic                     rd_ok;
   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         fill_ext;
   logic signed [WORD_W-1:0] sel_word;
   logic signed [WORD_W-1:0] result_word;
   ple_ctrl_type             ctrl;

   logic signed [WORD_W-1:0] cell_word [DEPTH];
   logic signed [WORD_W-1:0] cell_hit  [DEPTH];

   // Accept while the response register is empty or being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Range checks against the current fill count.
   assign pos_ext  = CMP_W'(req_position);
   assign fill_ext = CMP_W'(fill_ff);

   always_comb begin
      rd_ok  = 1'b0;
      ins_ok = 1'b0;
      del_ok = 1'b0;
      case (ple_op_type'(req_opcode))
         OP_READ:   rd_ok  = (pos_ext != '0) && (pos_ext <= fill_ext);
         OP_INSERT: ins_ok = (fill_ext < CMP_W'(DEPTH)) && (pos_ext != '0)
                             && (pos_ext <= fill_ext + CMP_W'(1));
         OP_DELETE: del_ok = (fill_ext != '0) && (pos_ext != '0) && (pos_ext <= fill_ext);
         default: begin
            rd_ok  = 1'b0;
            ins_ok = 1'b0;
            del_ok = 1'b0;
         end
      endcase
   end

   assign ok = rd_ok || ins_ok || del_ok;

   // Broadcast control to the cell row; only accepted, valid changes move data.
   always_comb begin
      ctrl.position    = req_position;
      ctrl.write_value = req_write_value;
      if (accept && ins_ok) begin
         ctrl.cmd = CELL_INSERT;
      end else if (accept && del_ok) begin
         ctrl.cmd = CELL_DELETE;
      end else begin
         ctrl.cmd = CELL_HOLD;
      end
   end

   // The row of cells, each wired to its two neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_word;
      logic signed [WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = req_write_value;
      end else begin : g_mid_l
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_mid_r
         assign right_word = cell_word[i+1];
      end

      ple_cell #(
         .IDX(i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i]),
         .hit_word   (cell_hit[i])
      );
   end

   // Merge the select bus: at most one cell matches the position.
   always_comb begin
      sel_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_word = sel_word | cell_hit[i];
      end
   end

   assign result_word = (rd_ok || del_ok) ? sel_word : '0;

   // Next fill count.
   always_comb begin
      fill_in = fill_ff;
      if (accept && ins_ok) begin
         fill_in = fill_ff + CW'(1);
      end else if (accept && del_ok) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= !ok;
         rsp_read_value_ff <= result_word;
         rsp_fill_level_ff <= LEVEL_W'(fill_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_fill_level = rsp_fill_level_ff;

`ifndef SYNTH
   // The count never passes the depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   // A successful insert grows the count by one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("insert did not grow the count");

   // A rejected request changes nothing in the count.
   a_reject_stable: assert property (@(posedge clock) disable iff (reset)
      (accept && !ok) |=> $stable(fill_ff))
      else $error("rejected request changed the count");

   // An error response carries a zero value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_read_value == '0))
      else $error("error response with nonzero value");
`endif

endmodule

`default_nettype wire

### rtl/ple_cell.sv
// One storage cell of the list row: holds one word and shifts to or from its neighbors.
// Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell
   import ple_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire logic                     clock,
   input  wire ple_ctrl_type             ctrl,
   input  wire logic signed [WORD_W-1:0] left_word,
   input  wire logic signed [WORD_W-1:0] right_word,
   output logic signed [WORD_W-1:0]      word,
   output logic signed [WORD_W-1:0]      hit_word
);

   // 1-based position that this cell holds.
   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX + 1);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;

   // Insert opens a gap at the position by taking the left word above it;
   // delete closes the gap by taking the right word from the position up.
   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (ctrl.position == MY_POS) begin
               data_in = ctrl.write_value;
            end else if (ctrl.position < MY_POS) begin
               data_in = left_word;
            end
         end
         CELL_DELETE: begin
            if (ctrl.position <= MY_POS) begin
               data_in = right_word;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // The addressed cell drives its word onto the merged read bus.
   assign word     = data_ff;
   assign hit_word = (ctrl.position == MY_POS) ? data_ff : '0;

endmodule

`default_nettype wire
